// ----- rtl/core/pixel_run_length_encoder_unit_macros.svh -----
// Assertion macros used by the encoder checker.
`ifndef PIXEL_RUN_LENGTH_ENCODER_UNIT_MACROS_SVH
`define PIXEL_RUN_LENGTH_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PRLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prle: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PRLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prle: next-cycle check failed");

`endif

// ----- rtl/core/prle_pkg.sv -----
// Shared constants and types of the pixel run-length encoder.
package prle_pkg;

	localparam int MAX_RUN     = 127;
	localparam int OFFSET_BITS = 23;
	localparam int RUN_W       = $clog2(MAX_RUN + 1);
	localparam int PIXEL_W     = 32;
	localparam int MAX_WR      = 4;
	localparam int WR_IDX_W    = $clog2(MAX_WR);
	localparam int WR_CNT_W    = $clog2(MAX_WR + 1);
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [7:0] HDR_REPEAT = 8'h80;
	localparam logic [7:0] HDR_SINGLE = 8'h01;
	localparam logic [2:0] BYTES_HDR  = 3'd1;
	localparam logic [2:0] BYTES_RGB  = 3'd3;
	localparam logic [2:0] BYTES_RGBA = 3'd4;

	localparam logic [PIXEL_W-1:0] MASK_RGB  = 32'h00FF_FFFF;
	localparam logic [PIXEL_W-1:0] MASK_RGBA = 32'hFFFF_FFFF;

	// one addressed byte write
	typedef struct packed {
		logic [OFFSET_BITS-1:0] offset;
		logic [PIXEL_W-1:0]     data;
		logic [2:0]             nbytes;
		logic                   eos;
	} wr_t;

	// all writes caused by one pixel
	typedef struct packed {
		logic [WR_CNT_W-1:0]   cnt;
		wr_t [MAX_WR-1:0]      wr;
	} bundle_t;

endpackage

// ----- rtl/core/prle_front.sv -----
// Front end: packet state machine, turns each pixel into a bundle of writes.
module prle_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 alpha_mode,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [7:0]           alpha,
	input  logic                 last_pixel,
	output logic                 push,
	output prle_pkg::bundle_t    bundle
);

	typedef enum logic [1:0] {M_IDLE, M_HOLD, M_LIT, M_REP} mode_t;

	mode_t                                mode_q;
	logic [prle_pkg::RUN_W-1:0]           cnt_q;
	logic [prle_pkg::PIXEL_W-1:0]         held_q;
	logic [prle_pkg::PIXEL_W-1:0]         run_q;
	logic [prle_pkg::OFFSET_BITS-1:0]     slot_q;
	logic [prle_pkg::OFFSET_BITS-1:0]     wptr_q;

	mode_t                                m;
	logic [prle_pkg::RUN_W-1:0]           c;
	logic [prle_pkg::PIXEL_W-1:0]         h;
	logic [prle_pkg::PIXEL_W-1:0]         r;
	logic [prle_pkg::OFFSET_BITS-1:0]     hs;
	logic [prle_pkg::OFFSET_BITS-1:0]     wp;
	logic [prle_pkg::WR_CNT_W-1:0]        n;
	logic [prle_pkg::PIXEL_W-1:0]         x;
	logic [prle_pkg::PIXEL_W-1:0]         msk;
	logic [2:0]                           nb;
	logic                                 do_open;
	logic                                 run_full;
	prle_pkg::bundle_t                    b;

	assign x   = {alpha, blue, green, red};
	assign msk = alpha_mode ? prle_pkg::MASK_RGBA : prle_pkg::MASK_RGB;
	assign nb  = alpha_mode ? prle_pkg::BYTES_RGBA : prle_pkg::BYTES_RGB;

	always_comb begin
		m        = mode_q;
		c        = cnt_q;
		h        = held_q;
		r        = run_q;
		hs       = slot_q;
		wp       = wptr_q;
		n        = '0;
		b        = '0;
		do_open  = 1'b0;
		run_full = (cnt_q >= prle_pkg::RUN_W'(prle_pkg::MAX_RUN));

		unique case (mode_q)
			M_IDLE: begin
				h = x;
				m = M_HOLD;
			end
			M_HOLD: begin
				do_open = 1'b1;
			end
			M_LIT: begin
				if (run_full) begin
					// literal full: patch its header, restart from held pixel
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{hs, 32'(8'(c)), prle_pkg::BYTES_HDR, 1'b0};
					n = n + 1'b1;
					do_open = 1'b1;
				end else if (((h ^ x) & msk) != '0) begin
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, h & msk, nb, 1'b0};
					n  = n + 1'b1;
					wp = wp + prle_pkg::OFFSET_BITS'(nb);
					c  = c + 1'b1;
					h  = x;
				end else begin
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{hs, 32'(8'(c)), prle_pkg::BYTES_HDR, 1'b0};
					n = n + 1'b1;
					r = h;
					c = prle_pkg::RUN_W'(2);
					h = x;
					m = M_REP;
				end
			end
			M_REP: begin
				if (!run_full && (((r ^ x) & msk) == '0)) begin
					c = c + 1'b1;
					h = x;
				end else begin
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] =
						'{wp, 32'(8'(c) | prle_pkg::HDR_REPEAT), prle_pkg::BYTES_HDR, 1'b0};
					n  = n + 1'b1;
					wp = wp + 1'b1;
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, r & msk, nb, 1'b0};
					n  = n + 1'b1;
					wp = wp + prle_pkg::OFFSET_BITS'(nb);
					h  = x;
					m  = M_HOLD;
				end
			end
		endcase

		// open a packet from the held pixel and the new one
		if (do_open) begin
			if (((h ^ x) & msk) != '0) begin
				hs = wp;
				wp = wp + 1'b1;
				b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, h & msk, nb, 1'b0};
				n  = n + 1'b1;
				wp = wp + prle_pkg::OFFSET_BITS'(nb);
				c  = prle_pkg::RUN_W'(1);
				m  = M_LIT;
			end else begin
				r = h;
				c = prle_pkg::RUN_W'(2);
				m = M_REP;
			end
			h = x;
		end

		// end of image: flush whatever is pending
		if (last_pixel) begin
			unique case (m)
				M_IDLE: begin
				end
				M_HOLD: begin
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] =
						'{wp, 32'(prle_pkg::HDR_SINGLE), prle_pkg::BYTES_HDR, 1'b0};
					n  = n + 1'b1;
					wp = wp + 1'b1;
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, h & msk, nb, 1'b0};
					n  = n + 1'b1;
					wp = wp + prle_pkg::OFFSET_BITS'(nb);
				end
				M_LIT: begin
					if (c < prle_pkg::RUN_W'(prle_pkg::MAX_RUN)) begin
						b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, h & msk, nb, 1'b0};
						n  = n + 1'b1;
						wp = wp + prle_pkg::OFFSET_BITS'(nb);
						c  = c + 1'b1;
						b.wr[n[prle_pkg::WR_IDX_W-1:0]] =
							'{hs, 32'(8'(c)), prle_pkg::BYTES_HDR, 1'b0};
						n  = n + 1'b1;
					end else begin
						b.wr[n[prle_pkg::WR_IDX_W-1:0]] =
							'{hs, 32'(8'(c)), prle_pkg::BYTES_HDR, 1'b0};
						n  = n + 1'b1;
						b.wr[n[prle_pkg::WR_IDX_W-1:0]] =
							'{wp, 32'(prle_pkg::HDR_SINGLE), prle_pkg::BYTES_HDR, 1'b0};
						n  = n + 1'b1;
						wp = wp + 1'b1;
						b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, h & msk, nb, 1'b0};
						n  = n + 1'b1;
						wp = wp + prle_pkg::OFFSET_BITS'(nb);
					end
				end
				M_REP: begin
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] =
						'{wp, 32'(8'(c) | prle_pkg::HDR_REPEAT), prle_pkg::BYTES_HDR, 1'b0};
					n  = n + 1'b1;
					wp = wp + 1'b1;
					b.wr[n[prle_pkg::WR_IDX_W-1:0]] = '{wp, r & msk, nb, 1'b0};
					n  = n + 1'b1;
					wp = wp + prle_pkg::OFFSET_BITS'(nb);
				end
			endcase
			if (n != '0) begin
				b.wr[prle_pkg::WR_IDX_W'(n - 1'b1)].eos = 1'b1;
			end
		end

		b.cnt = n;
	end

	assign push   = accept && (n != '0);
	assign bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= '0;
			held_q <= '0;
			run_q  <= '0;
			slot_q <= '0;
			wptr_q <= '0;
		end else if (accept) begin
			if (last_pixel) begin
				mode_q <= M_IDLE;
				cnt_q  <= '0;
				held_q <= '0;
				run_q  <= '0;
				slot_q <= '0;
				wptr_q <= '0;
			end else begin
				mode_q <= m;
				cnt_q  <= c;
				held_q <= h;
				run_q  <= r;
				slot_q <= hs;
				wptr_q <= wp;
			end
		end
	end

endmodule

// ----- rtl/core/prle_queue.sv -----
// Small bundle queue between front and back end.
module prle_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  prle_pkg::bundle_t    push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output prle_pkg::bundle_t    head
);

	prle_pkg::bundle_t             mem_q [prle_pkg::QDEPTH];
	logic [prle_pkg::QAW-1:0]      wr_q;
	logic [prle_pkg::QAW-1:0]      rd_q;
	logic [prle_pkg::QAW:0]        cnt_q;

	assign full      = (cnt_q == (prle_pkg::QAW+1)'(prle_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_q <= rd_q + 1'b1;
			end
			priority case (1'b1)
				(push && !full) && !(pop && not_empty): cnt_q <= cnt_q + 1'b1;
				!(push && !full) && (pop && not_empty): cnt_q <= cnt_q - 1'b1;
				default:                                cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/prle_back.sv -----
// Back end: plays out one bundle as a sequence of writes, one per cycle while not stalled.
module prle_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_not_empty,
	input  prle_pkg::bundle_t                 q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [prle_pkg::OFFSET_BITS-1:0]  out_offset,
	output logic [31:0]                       out_data,
	output logic [2:0]                        out_bytes,
	output logic                              end_of_stream
);

	prle_pkg::bundle_t               cur_q;
	logic                            cur_v_q;
	logic [prle_pkg::WR_IDX_W-1:0]   idx_q;
	logic                            taken;
	logic                            last_wr;
	prle_pkg::wr_t                   wr;

	assign taken   = cur_v_q && !out_stall;
	assign last_wr = (prle_pkg::WR_CNT_W'(idx_q) + 1'b1) == cur_q.cnt;
	assign q_pop   = q_not_empty && (!cur_v_q || (taken && last_wr));

	assign wr            = cur_q.wr[idx_q];
	assign out_valid     = cur_v_q;
	assign out_offset    = wr.offset;
	assign out_data      = wr.data;
	assign out_bytes     = wr.nbytes;
	assign end_of_stream = wr.eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
			idx_q   <= '0;
		end else if (taken) begin
			if (last_wr) begin
				cur_v_q <= 1'b0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

endmodule

// ----- rtl/core/pixel_run_length_encoder_unit.sv -----
// A pixel's writes reach the output via the bundle queue and the back end's bundle register.
// Throughput: one pixel per cycle while the four-bundle queue has room; writes leave at one
//   per cycle when not stalled; a pixel yields zero to four of them (bursts at packet ends).
// in_stall rises only when the queue between the packet machine and the write player is full.
// Reset (arst_n low, asynchronous): packet state, pointers, queue cleared; alpha_mode = 0.
module pixel_run_length_encoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: alpha_mode
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	// pixel input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        red,
	input  logic [7:0]                        green,
	input  logic [7:0]                        blue,
	input  logic [7:0]                        alpha,
	input  logic                              last_pixel,
	// byte writes out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [prle_pkg::OFFSET_BITS-1:0]  out_offset,
	output logic [31:0]                       out_data,
	output logic [2:0]                        out_bytes,
	output logic                              end_of_stream
);

	logic               alpha_mode_q;
	logic               q_full;
	logic               q_not_empty;
	logic               q_pop;
	logic               push;
	logic               accept;
	prle_pkg::bundle_t  bundle;
	prle_pkg::bundle_t  q_head;

	// The user must issue register writes only while idle; the block does not enforce this and is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			alpha_mode_q <= cfg_data;
		end
	end

	// A pixel goes in whenever the queue can take its bundle.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Front: lookahead pixel, run counting, header slot reservation and flush.
	prle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.alpha_mode (alpha_mode_q),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel),
		.push       (push),
		.bundle     (bundle)
	);

	// Bundles with no write never enter the queue.
	prle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: one write per cycle from the current bundle, held steady under stall.
	prle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_offset    (out_offset),
		.out_data      (out_data),
		.out_bytes     (out_bytes),
		.end_of_stream (end_of_stream)
	);

endmodule

// ----- rtl/core/prle_checker.sv -----
// Port-level checks on the encoder output, bound to the top level.
`include "pixel_run_length_encoder_unit_macros.svh"

module prle_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [prle_pkg::OFFSET_BITS-1:0]  out_offset,
	input logic [31:0]                       out_data,
	input logic [2:0]                        out_bytes,
	input logic                              end_of_stream
);

	// a stalled write holds
	`PRLE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_offset) && $stable(out_data) && $stable(out_bytes)
		&& $stable(end_of_stream))

	// a write is a header byte or a whole pixel
	`PRLE_ASSERT_IMP(a_bytes_legal, out_valid,
		out_bytes == prle_pkg::BYTES_HDR || out_bytes == prle_pkg::BYTES_RGB
		|| out_bytes == prle_pkg::BYTES_RGBA)

	// headers carry only one byte
	`PRLE_ASSERT_IMP(a_hdr_byte, out_valid && out_bytes == prle_pkg::BYTES_HDR,
		out_data[31:8] == 24'd0 && out_data[7:0] != 8'd0)

	// RGB pixels have no alpha byte
	`PRLE_ASSERT_IMP(a_rgb_no_alpha, out_valid && out_bytes == prle_pkg::BYTES_RGB,
		out_data[31:24] == 8'd0)

endmodule

bind pixel_run_length_encoder_unit prle_checker u_prle_checker (.*);

// ----- bench/pixel_run_length_encoder_unit_test.sv -----
// Self-checking bench for the pixel run-length encoder: directed and random pixels in, predicted writes out.
module pixel_run_length_encoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import prle_pkg::*;

	// alpha_mode register values
	localparam logic MODE_RGB  = 1'b0;
	localparam logic MODE_RGBA = 1'b1;

	localparam int IDLE_PCT       = 33;    // chance of an idle cycle on either side
	localparam int HOLD_CYCLES    = 200;   // long receiver hold-off to back up the queue
	localparam int SETTLE_CYCLES  = 4;     // settle margin after the last expected write
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all

	// packet machine states of the encoder model
	typedef enum logic [1:0] {RUN_IDLE, RUN_HOLD, RUN_LIT, RUN_REP} run_mode_e;

	// one pixel item as offered on the input channel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_px;
	} pixel_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             red;
	logic [7:0]             green;
	logic [7:0]             blue;
	logic [7:0]             alpha;
	logic                   last_pixel;
	logic                   out_valid;
	logic                   out_stall;
	logic [OFFSET_BITS-1:0] out_offset;
	logic [31:0]            out_data;
	logic [2:0]             out_bytes;
	logic                   end_of_stream;

	// encoder model state, updated as each pixel is accepted
	logic                   alpha_on;
	run_mode_e              enc_mode;
	logic [RUN_W-1:0]       enc_count;
	logic [31:0]            enc_held;
	logic [31:0]            enc_run_pix;
	logic [OFFSET_BITS-1:0] enc_hdr_slot;
	logic [OFFSET_BITS-1:0] enc_wptr;

	wr_t    step_wr[$];          // writes caused by the pixel being modeled
	wr_t    expected_writes[$];  // writes still owed by the block, oldest first
	pixel_t pixel_q[$];          // pixels waiting to be offered
	pixel_t next_px;
	wr_t    want;

	logic [31:0] palette [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000};

	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_req;
	int   hold_left;
	logic pix_taken;
	logic moved;
	int   quiet_cycles;
	int   write_no;
	int   errors;

	pixel_run_length_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.last_pixel    (last_pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_offset    (out_offset),
		.out_data      (out_data),
		.out_bytes     (out_bytes),
		.end_of_stream (end_of_stream)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic note_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// Encoder model
	// ---------------------------------------------------------------

	// in RGB mode alpha is neither compared nor written
	function automatic logic [31:0] pix_mask();
		return alpha_on ? MASK_RGBA : MASK_RGB;
	endfunction

	function automatic bit same_pix(logic [31:0] a, logic [31:0] b);
		return ((a ^ b) & pix_mask()) == '0;
	endfunction

	function automatic void emit_wr(logic [OFFSET_BITS-1:0] off, logic [31:0] data,
			logic [2:0] nb);
		wr_t w;
		w.offset = off;
		w.data   = data;
		w.nbytes = nb;
		w.eos    = 1'b0;
		step_wr.push_back(w);
	endfunction

	function automatic void put_pixel(logic [31:0] p);
		logic [2:0] nb;
		nb = alpha_on ? BYTES_RGBA : BYTES_RGB;
		emit_wr(enc_wptr, p & pix_mask(), nb);
		enc_wptr = enc_wptr + nb;
	endfunction

	function automatic void put_header(logic [7:0] h);
		emit_wr(enc_wptr, {24'h0, h}, BYTES_HDR);
		enc_wptr = enc_wptr + 1'b1;
	endfunction

	// literal header goes back into the slot reserved when the literal opened
	function automatic void patch_header();
		emit_wr(enc_hdr_slot, {{(32-RUN_W){1'b0}}, enc_count}, BYTES_HDR);
	endfunction

	// held pixel plus new one decide literal or repeat
	function automatic void open_packet(logic [31:0] x);
		if (!same_pix(enc_held, x)) begin
			enc_hdr_slot = enc_wptr;
			enc_wptr     = enc_wptr + 1'b1;
			put_pixel(enc_held);
			enc_count = RUN_W'(1);
			enc_mode  = RUN_LIT;
		end else begin
			enc_run_pix = enc_held;
			enc_count   = RUN_W'(2);
			enc_mode    = RUN_REP;
		end
		enc_held = x;
	endfunction

	function automatic void advance_pixel(logic [31:0] x);
		case (enc_mode)
			RUN_IDLE: begin
				enc_held = x;
				enc_mode = RUN_HOLD;
			end
			RUN_HOLD: begin
				open_packet(x);
			end
			RUN_LIT: begin
				if (enc_count >= MAX_RUN) begin
					// literal full: close it and start over from the held pixel
					patch_header();
					enc_mode = RUN_HOLD;
					open_packet(x);
				end else if (!same_pix(enc_held, x)) begin
					put_pixel(enc_held);
					enc_count++;
					enc_held = x;
				end else begin
					// held pixel starts a repeat, literal closes without it
					patch_header();
					enc_run_pix = enc_held;
					enc_count   = RUN_W'(2);
					enc_held    = x;
					enc_mode    = RUN_REP;
				end
			end
			default: begin
				if (enc_count < MAX_RUN && same_pix(enc_run_pix, x)) begin
					enc_count++;
					enc_held = x;
				end else begin
					put_header(HDR_REPEAT | {1'b0, enc_count});
					put_pixel(enc_run_pix);
					enc_held = x;
					enc_mode = RUN_HOLD;
				end
			end
		endcase
	endfunction

	function automatic void flush_image();
		case (enc_mode)
			RUN_HOLD: begin
				put_header(HDR_SINGLE);
				put_pixel(enc_held);
			end
			RUN_LIT: begin
				if (enc_count < MAX_RUN) begin
					put_pixel(enc_held);
					enc_count++;
					patch_header();
				end else begin
					patch_header();
					put_header(HDR_SINGLE);
					put_pixel(enc_held);
				end
			end
			RUN_REP: begin
				put_header(HDR_REPEAT | {1'b0, enc_count});
				put_pixel(enc_run_pix);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void clear_image();
		enc_mode     = RUN_IDLE;
		enc_count    = '0;
		enc_held     = '0;
		enc_run_pix  = '0;
		enc_hdr_slot = '0;
		enc_wptr     = '0;
	endfunction

	// works out every write one accepted pixel causes and queues them
	function automatic void predict_pixel(pixel_t it);
		logic [31:0] x;
		x = {it.alpha, it.blue, it.green, it.red};
		step_wr.delete();
		advance_pixel(x);
		if (it.last_px) begin
			flush_image();
			if (step_wr.size() > 0)
				step_wr[step_wr.size()-1].eos = 1'b1;
			clear_image();
		end
		foreach (step_wr[i])
			expected_writes.push_back(step_wr[i]);
	endfunction

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------

	function automatic void push_pixel(logic [31:0] w, bit tail);
		pixel_t p;
		p.red     = w[7:0];
		p.green   = w[15:8];
		p.blue    = w[23:16];
		p.alpha   = w[31:24];
		p.last_px = tail;
		pixel_q.push_back(p);
	endfunction

	// image of n pixels mixing runs, alpha-only changes, palette hits and noise
	function automatic void queue_mix(int n, bit closed);
		logic [31:0] w;
		w = $urandom;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					// same as previous pixel, extends a run
				end
				4: w[31:24] = 8'($urandom_range(255));
				5: w = palette[2'($urandom_range(3))];
				default: w = $urandom;
			endcase
			push_pixel(w, closed && i == n - 1);
		end
	endfunction

	// consecutive pixels all differ in RGB, so they differ in both modes
	function automatic void queue_literal(int n, bit closed);
		logic [31:0] w;
		logic [31:0] prev;
		prev = $urandom;
		for (int i = 0; i < n; i++) begin
			w = $urandom;
			if (((w ^ prev) & MASK_RGB) == '0)
				w[0] = ~w[0];
			push_pixel(w, closed && i == n - 1);
			prev = w;
		end
	endfunction

	function automatic void queue_repeat(int n, bit closed);
		logic [31:0] w;
		w = $urandom;
		for (int i = 0; i < n; i++)
			push_pixel(w, closed && i == n - 1);
	endfunction

	// ---------------------------------------------------------------
	// Pixel driver: new item only once the current one is taken
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || pix_taken) begin
			if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_px = pixel_q.pop_front();
				in_valid   <= 1'b1;
				red        <= next_px.red;
				green      <= next_px.green;
				blue       <= next_px.blue;
				alpha      <= next_px.alpha;
				last_pixel <= next_px.last_px;
			end else begin
				in_valid <= 1'b0;
			end
		end
		pix_taken = 1'b0;
	end

	// ---------------------------------------------------------------
	// Write receiver: random stalls, plus one long hold-off on request
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Monitor: handshakes at the rising edge, checker and watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				alpha_on = cfg_data;
				moved    = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				write_no++;
				if (expected_writes.size() == 0) begin
					note_error($sformatf("write %0d at offset %0d data %h with none pending",
						write_no, out_offset, out_data));
				end else begin
					want = expected_writes.pop_front();
					if (out_offset !== want.offset)
						note_error($sformatf("write %0d out_offset %0d, want %0d",
							write_no, out_offset, want.offset));
					if (out_data !== want.data)
						note_error($sformatf("write %0d out_data %h, want %h",
							write_no, out_data, want.data));
					if (out_bytes !== want.nbytes)
						note_error($sformatf("write %0d out_bytes %0d, want %0d",
							write_no, out_bytes, want.nbytes));
					if (end_of_stream !== want.eos)
						note_error($sformatf("write %0d end_of_stream %b, want %b",
							write_no, end_of_stream, want.eos));
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				predict_pixel('{red, green, blue, alpha, last_pixel});
				pix_taken = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR @%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencing
	// ---------------------------------------------------------------

	// register writes happen only with nothing in flight
	task automatic wait_quiet();
		while (pixel_q.size() > 0 || in_valid || expected_writes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_alpha_mode(input logic mode);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		in_valid      = 1'b0;
		red           = '0;
		green         = '0;
		blue          = '0;
		alpha         = '0;
		last_pixel    = 1'b0;
		out_stall     = 1'b0;
		send_idle_pct = IDLE_PCT;
		recv_idle_pct = IDLE_PCT;
		hold_req      = 1'b0;
		hold_left     = 0;
		pix_taken     = 1'b0;
		quiet_cycles  = 0;
		write_no      = 0;
		errors        = 0;
		alpha_on      = MODE_RGB;
		clear_image();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// RGB directed: single-pixel images at both extremes, alpha ignored in compares,
		// two-pixel literal and repeat, literal running into a repeat
		set_alpha_mode(MODE_RGB);
		push_pixel(32'h0000_0000, 1'b1);
		push_pixel(32'hFFFF_FFFF, 1'b1);
		push_pixel(32'hFFFF_FFFF, 1'b0);
		push_pixel(32'h00FF_FFFF, 1'b0);
		push_pixel(32'hFFFF_FFFF, 1'b0);
		push_pixel(32'h1234_5678, 1'b0);
		push_pixel(32'h9ABC_DEF0, 1'b0);
		push_pixel(32'h9ABC_DEF0, 1'b1);
		push_pixel(32'h0000_0001, 1'b0);
		push_pixel(32'h0000_0002, 1'b1);
		push_pixel(32'h8080_8080, 1'b0);
		push_pixel(32'h8080_8080, 1'b1);
		push_pixel(32'h0000_0011, 1'b0);
		push_pixel(32'h0000_0022, 1'b0);
		push_pixel(32'h0000_0033, 1'b0);
		push_pixel(32'h0000_0033, 1'b0);
		push_pixel(32'h0000_0033, 1'b0);
		push_pixel(32'h0000_0044, 1'b1);
		wait_quiet();

		// RGBA directed: alpha alone separates pixels; the last image is left open
		set_alpha_mode(MODE_RGBA);
		push_pixel(32'h01AA_BBCC, 1'b0);
		push_pixel(32'h02AA_BBCC, 1'b0);
		push_pixel(32'h02AA_BBCC, 1'b0);
		push_pixel(32'h02AA_BBCC, 1'b1);
		push_pixel(32'h7F00_0000, 1'b1);
		push_pixel(32'h5566_7788, 1'b0);
		push_pixel(32'h6666_7788, 1'b0);
		push_pixel(32'h7766_7788, 1'b0);
		wait_quiet();

		// back to RGB mid-image: the held RGBA pixel now matches on RGB only
		set_alpha_mode(MODE_RGB);
		push_pixel(32'h8866_7788, 1'b0);
		push_pixel(32'h8866_7788, 1'b1);
		// full-length literal that ends the image; receiver holds off meanwhile
		send_idle_pct = 0;
		hold_req      = 1'b1;
		queue_literal(MAX_RUN + 1, 1'b1);
		while (hold_req || hold_left > 0)
			@(posedge clk);
		send_idle_pct = IDLE_PCT;
		repeat (4) queue_mix($urandom_range(1, 12), 1'b1);
		wait_quiet();

		// RGBA, no idling on either side: repeat and literal past the run limit
		set_alpha_mode(MODE_RGBA);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_repeat(MAX_RUN + 2, 1'b1);
		queue_literal(MAX_RUN + 2, 1'b1);
		wait_quiet();
		send_idle_pct = IDLE_PCT;
		recv_idle_pct = IDLE_PCT;

		// random images; the last one stays open across the mode change
		set_alpha_mode(MODE_RGB);
		repeat (3) queue_mix($urandom_range(1, 12), 1'b1);
		queue_mix($urandom_range(2, 10), 1'b0);
		wait_quiet();

		set_alpha_mode(MODE_RGBA);
		repeat (4) queue_mix($urandom_range(1, 12), 1'b1);
		wait_quiet();

		if (expected_writes.size() != 0)
			note_error($sformatf("%0d writes never arrived", expected_writes.size()));
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
